// ===== hdl/snfs_pkg.sv =====
package snfs_pkg;

  // Flash geometry
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_BYTES   = 256;
  localparam int SECT_W       = $clog2(SECTOR_BYTES);
  localparam int PAGE_W       = $clog2(PAGE_BYTES);
  localparam int MAX_RES      = 4;

  // Input item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_SPI  = 2'd2;

  // Host commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_ID    = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_CSLOW  = 3'd0;
  localparam logic [2:0] ACT_CSHIGH = 3'd1;
  localparam logic [2:0] ACT_XCHG   = 3'd2;
  localparam logic [2:0] ACT_HOST   = 3'd3;
  localparam logic [2:0] ACT_REQ    = 3'd4;
  localparam logic [2:0] ACT_DONE   = 3'd5;

  // Flash opcodes
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_ID    = 8'h90;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] OPC_ERASE = 8'h20;
  localparam logic [7:0] OPC_PROG  = 8'h02;
  localparam logic [7:0] DUMMY     = 8'hFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  spi_byte;
    logic [7:0]  host_byte;
    logic [15:0] device_id;
    logic        last;
  } res_t;

endpackage

// ===== hdl/snfs_cmd_if.sv =====
interface snfs_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  op;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, kind, op, address, length, data_byte, input ready);
  modport sink (input valid, kind, op, address, length, data_byte, output ready);
endinterface

// ===== hdl/snfs_res_if.sv =====
interface snfs_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  spi_byte;
  logic [7:0]  host_byte;
  logic [15:0] device_id;
  logic        last;

  modport source (output valid, action, spi_byte, host_byte, device_id, last, input ready);
  modport sink (input valid, action, spi_byte, host_byte, device_id, last, output ready);
endinterface

// ===== hdl/spi_nor_flash_sequencer_unit.sv =====
// SPI NOR flash command sequencer.
// cmd channel: one item per transfer; kind selects a host command (read, write,
//   read id), a host write byte, or a byte received from the last SPI exchange.
// res channel: actions for the SPI shifter and the host (chip select, byte
//   exchange, read byte, host byte request, done); last marks the final result
//   of an input item. An item gives zero to three results.
// Latency: the first result of an item is shown the cycle after its transfer.
// Throughput: one item per cycle while items give at most one result and the
//   receiver is ready; longer items hold the input until the last result goes.
// The sector buffer is a 4096 x 8 synchronous RAM; the byte to program next is
//   prefetched from the state being written, so page data never waits on a read.
// Reset clears the phase and the result queue; no buffer clearing pass runs,
//   and the block accepts items in the first cycle after reset.
// When the receiver stalls, results wait in the queue and cmd.ready drops once
//   the last queued result cannot leave in the same cycle.
module spi_nor_flash_sequencer_unit
  import snfs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  snfs_cmd_if.sink  cmd,
  snfs_res_if.source res
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_RD_HDR    = 5'd1;
  localparam logic [4:0] PH_RD_DATA   = 5'd2;
  localparam logic [4:0] PH_ID_HDR    = 5'd3;
  localparam logic [4:0] PH_ID_HI     = 5'd4;
  localparam logic [4:0] PH_ID_LO     = 5'd5;
  localparam logic [4:0] PH_W_RD_HDR  = 5'd6;
  localparam logic [4:0] PH_W_RD_DATA = 5'd7;
  localparam logic [4:0] PH_ER_WE     = 5'd8;
  localparam logic [4:0] PH_E1_CMD    = 5'd9;
  localparam logic [4:0] PH_E1_STAT   = 5'd10;
  localparam logic [4:0] PH_ER_HDR    = 5'd11;
  localparam logic [4:0] PH_E2_CMD    = 5'd12;
  localparam logic [4:0] PH_E2_STAT   = 5'd13;
  localparam logic [4:0] PH_MERGE     = 5'd14;
  localparam logic [4:0] PH_PG_WE     = 5'd15;
  localparam logic [4:0] PH_PG_HDR    = 5'd16;
  localparam logic [4:0] PH_PG_DATA   = 5'd17;
  localparam logic [4:0] PH_PG_CMD    = 5'd18;
  localparam logic [4:0] PH_PG_STAT   = 5'd19;

  localparam logic [SECT_W:0] SECT_FULL = (SECT_W+1)'(SECTOR_BYTES);

  logic [4:0]        phase, phase_next;
  logic [23:0]       cur_address, cur_address_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [SECT_W-1:0] sector_offset, sector_offset_next;
  logic [SECT_W:0]   chunk_count, chunk_count_next;
  logic [SECT_W:0]   byte_index, byte_index_next;
  logic [15:0]       id_value, id_value_next;
  logic [2:0]        hdr_pos, hdr_pos_next;

  logic [7:0]        sbuf [SECTOR_BYTES];
  logic [7:0]        sbuf_q;
  logic              wr_en;
  logic [SECT_W-1:0] wr_addr;
  logic [SECT_W-1:0] rd_addr;

  res_t       rlist [MAX_RES];
  logic [2:0] rcnt;
  logic       take;
  logic       q_ready;

  assign take      = cmd.valid && cmd.ready;
  assign cmd.ready = q_ready;

  function automatic res_t mk(logic [2:0] a, logic [7:0] sb, logic [7:0] hb,
                              logic [15:0] id);
    res_t r;
    r.action    = a;
    r.spi_byte  = sb;
    r.host_byte = hb;
    r.device_id = id;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] addr_byte(logic [23:0] a, logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd1:    b = a[23:16];
      3'd2:    b = a[15:8];
      default: b = a[7:0];
    endcase
    return b;
  endfunction

  // Sequencer next state and results of one item
  always_comb begin
    logic [2:0]        n;
    logic [2:0]        hp;
    logic [SECT_W:0]   bi1;
    logic [SECT_W:0]   rem;
    logic [23:0]       pa;
    logic [23:0]       pa1;
    logic              busy;
    phase_next         = phase;
    cur_address_next   = cur_address;
    bytes_left_next    = bytes_left;
    sector_offset_next = sector_offset;
    chunk_count_next   = chunk_count;
    byte_index_next    = byte_index;
    id_value_next      = id_value;
    hdr_pos_next       = hdr_pos;
    wr_en              = 1'b0;
    wr_addr            = byte_index[SECT_W-1:0];
    n                  = 3'd0;
    hp                 = hdr_pos + 3'd1;
    bi1                = byte_index + 1'b1;
    rem                = SECT_FULL - {1'b0, cmd.address[SECT_W-1:0]};
    pa                 = cur_address + 24'(byte_index);
    pa1                = cur_address + 24'(bi1);
    busy               = cmd.data_byte[0];
    for (int i = 0; i < MAX_RES; i++) begin
      rlist[i] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
    end

    if (phase == PH_IDLE) begin
      if (cmd.kind == KIND_CMD) begin
        case (cmd.op)
          CMD_READ: begin
            cur_address_next = cmd.address;
            bytes_left_next  = cmd.length;
            hdr_pos_next     = 3'd0;
            rlist[0] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_XCHG, OPC_READ, 8'h00, 16'h0000);
            n = 3'd2;
            phase_next = PH_RD_HDR;
          end
          CMD_WRITE: begin
            cur_address_next   = {cmd.address[23:SECT_W], {SECT_W{1'b0}}};
            sector_offset_next = cmd.address[SECT_W-1:0];
            bytes_left_next    = cmd.length;
            chunk_count_next   = ({8'h00, cmd.length} <= 24'(rem)) ?
                                 (SECT_W+1)'(cmd.length) : rem;
            hdr_pos_next = 3'd0;
            rlist[0] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_XCHG, OPC_READ, 8'h00, 16'h0000);
            n = 3'd2;
            phase_next = PH_W_RD_HDR;
          end
          CMD_ID: begin
            hdr_pos_next  = 3'd0;
            id_value_next = 16'h0000;
            rlist[0] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_XCHG, OPC_ID, 8'h00, 16'h0000);
            n = 3'd2;
            phase_next = PH_ID_HDR;
          end
          default: n = 3'd0;
        endcase
      end
    end else if (phase == PH_MERGE) begin
      if (cmd.kind == KIND_HOST) begin
        wr_en   = 1'b1;
        wr_addr = sector_offset + byte_index[SECT_W-1:0];
        if (bi1 < chunk_count) begin
          byte_index_next = bi1;
          rlist[0] = mk(ACT_REQ, 8'h00, 8'h00, 16'h0000);
          n = 3'd1;
        end else begin
          byte_index_next = '0;
          rlist[0] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
          rlist[1] = mk(ACT_XCHG, OPC_WREN, 8'h00, 16'h0000);
          n = 3'd2;
          phase_next = PH_PG_WE;
        end
      end
    end else if (cmd.kind == KIND_SPI) begin
      case (phase)
        PH_RD_HDR: begin
          hdr_pos_next = hp;
          if (hp < 3'd4) begin
            rlist[0] = mk(ACT_XCHG, addr_byte(cur_address, hp), 8'h00, 16'h0000);
            n = 3'd1;
          end else if (bytes_left != 16'd0) begin
            rlist[0] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
            n = 3'd1;
            phase_next = PH_RD_DATA;
          end else begin
            rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_DONE, 8'h00, 8'h00, 16'h0000);
            n = 3'd2;
            phase_next = PH_IDLE;
          end
        end
        PH_RD_DATA: begin
          rlist[0] = mk(ACT_HOST, 8'h00, cmd.data_byte, 16'h0000);
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left > 16'd1) begin
            rlist[1] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
            n = 3'd2;
          end else begin
            bytes_left_next = 16'd0;
            rlist[1] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_DONE, 8'h00, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_IDLE;
          end
        end
        PH_ID_HDR: begin
          hdr_pos_next = hp;
          if (hp < 3'd4) begin
            rlist[0] = mk(ACT_XCHG, 8'h00, 8'h00, 16'h0000);
          end else begin
            rlist[0] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
            phase_next = PH_ID_HI;
          end
          n = 3'd1;
        end
        PH_ID_HI: begin
          id_value_next = {cmd.data_byte, 8'h00};
          rlist[0] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
          n = 3'd1;
          phase_next = PH_ID_LO;
        end
        PH_ID_LO: begin
          id_value_next = {id_value[15:8], cmd.data_byte};
          rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
          rlist[1] = mk(ACT_DONE, 8'h00, 8'h00, {id_value[15:8], cmd.data_byte});
          n = 3'd2;
          phase_next = PH_IDLE;
        end
        PH_W_RD_HDR: begin
          hdr_pos_next = hp;
          if (hp < 3'd4) begin
            rlist[0] = mk(ACT_XCHG, addr_byte(cur_address, hp), 8'h00, 16'h0000);
          end else begin
            byte_index_next = '0;
            rlist[0] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
            phase_next = PH_W_RD_DATA;
          end
          n = 3'd1;
        end
        PH_W_RD_DATA: begin
          wr_en = 1'b1;
          byte_index_next = bi1;
          if (bi1 < SECT_FULL) begin
            rlist[0] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
            n = 3'd1;
          end else begin
            rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_WREN, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_ER_WE;
          end
        end
        PH_ER_WE: begin
          rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
          rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
          rlist[2] = mk(ACT_XCHG, OPC_RDSR, 8'h00, 16'h0000);
          n = 3'd3;
          phase_next = PH_E1_CMD;
        end
        PH_E1_CMD, PH_E2_CMD, PH_PG_CMD: begin
          rlist[0] = mk(ACT_XCHG, DUMMY, 8'h00, 16'h0000);
          n = 3'd1;
          phase_next = phase + 5'd1;
        end
        PH_E1_STAT, PH_E2_STAT, PH_PG_STAT: begin
          rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
          if (busy) begin
            // still busy: poll status again
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_RDSR, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = phase - 5'd1;
          end else if (phase == PH_E1_STAT) begin
            hdr_pos_next = 3'd0;
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_ERASE, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_ER_HDR;
          end else if (phase == PH_E2_STAT) begin
            byte_index_next = '0;
            if (chunk_count != '0) begin
              rlist[1] = mk(ACT_REQ, 8'h00, 8'h00, 16'h0000);
              n = 3'd2;
              phase_next = PH_MERGE;
            end else begin
              rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
              rlist[2] = mk(ACT_XCHG, OPC_WREN, 8'h00, 16'h0000);
              n = 3'd3;
              phase_next = PH_PG_WE;
            end
          end else if (byte_index < SECT_FULL) begin
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_WREN, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_PG_WE;
          end else if (bytes_left <= 16'(chunk_count)) begin
            rlist[1] = mk(ACT_DONE, 8'h00, 8'h00, 16'h0000);
            n = 3'd2;
            phase_next = PH_IDLE;
          end else begin
            // next sector of a multi-sector write
            bytes_left_next    = bytes_left - 16'(chunk_count);
            cur_address_next   = cur_address + 24'(SECTOR_BYTES);
            sector_offset_next = '0;
            chunk_count_next   = (bytes_left_next > 16'(SECTOR_BYTES)) ?
                                 SECT_FULL : (SECT_W+1)'(bytes_left_next);
            hdr_pos_next = 3'd0;
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_READ, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_W_RD_HDR;
          end
        end
        PH_ER_HDR: begin
          hdr_pos_next = hp;
          if (hp < 3'd4) begin
            rlist[0] = mk(ACT_XCHG, addr_byte(cur_address, hp), 8'h00, 16'h0000);
            n = 3'd1;
          end else begin
            rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_RDSR, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_E2_CMD;
          end
        end
        PH_PG_WE: begin
          hdr_pos_next = 3'd0;
          rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
          rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
          rlist[2] = mk(ACT_XCHG, OPC_PROG, 8'h00, 16'h0000);
          n = 3'd3;
          phase_next = PH_PG_HDR;
        end
        PH_PG_HDR: begin
          hdr_pos_next = hp;
          if (hp < 3'd4) begin
            rlist[0] = mk(ACT_XCHG, addr_byte(pa, hp), 8'h00, 16'h0000);
          end else begin
            rlist[0] = mk(ACT_XCHG, sbuf_q, 8'h00, 16'h0000);
            phase_next = PH_PG_DATA;
          end
          n = 3'd1;
        end
        PH_PG_DATA: begin
          byte_index_next = bi1;
          if (bi1 < SECT_FULL && pa1[PAGE_W-1:0] != '0) begin
            rlist[0] = mk(ACT_XCHG, sbuf_q, 8'h00, 16'h0000);
            n = 3'd1;
          end else begin
            rlist[0] = mk(ACT_CSHIGH, 8'h00, 8'h00, 16'h0000);
            rlist[1] = mk(ACT_CSLOW, 8'h00, 8'h00, 16'h0000);
            rlist[2] = mk(ACT_XCHG, OPC_RDSR, 8'h00, 16'h0000);
            n = 3'd3;
            phase_next = PH_PG_CMD;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          n = 3'd0;
        end
      endcase
    end

    if (n != 3'd0) begin
      rlist[2'(n - 3'd1)].last = 1'b1;
    end
    rcnt = n;

    if (!take) begin
      phase_next         = phase;
      cur_address_next   = cur_address;
      bytes_left_next    = bytes_left;
      sector_offset_next = sector_offset;
      chunk_count_next   = chunk_count;
      byte_index_next    = byte_index;
      id_value_next      = id_value;
      hdr_pos_next       = hdr_pos;
      wr_en              = 1'b0;
    end

    // prefetch the byte the next program step sends
    rd_addr = (phase_next == PH_PG_DATA) ? SECT_W'(byte_index_next + 1'b1) :
                                           byte_index_next[SECT_W-1:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cur_address   <= '0;
      bytes_left    <= '0;
      sector_offset <= '0;
      chunk_count   <= '0;
      byte_index    <= '0;
      id_value      <= '0;
      hdr_pos       <= '0;
    end else begin
      phase         <= phase_next;
      cur_address   <= cur_address_next;
      bytes_left    <= bytes_left_next;
      sector_offset <= sector_offset_next;
      chunk_count   <= chunk_count_next;
      byte_index    <= byte_index_next;
      id_value      <= id_value_next;
      hdr_pos       <= hdr_pos_next;
    end
  end

  // Sector buffer RAM, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sbuf[wr_addr] <= cmd.data_byte;
    end
    sbuf_q <= sbuf[rd_addr];
  end

  snfs_res_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .load_cnt   (rcnt),
    .load_items (rlist),
    .load_ready (q_ready),
    .res        (res)
  );

endmodule

// ===== hdl/snfs_res_queue.sv =====
module snfs_res_queue
  import snfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [2:0] load_cnt,
  input  res_t       load_items [MAX_RES],
  output logic       load_ready,
  snfs_res_if.source res
);

  res_t       items [MAX_RES];
  logic [2:0] cnt;
  logic [1:0] idx;
  logic       take;

  assign take       = res.valid && res.ready;
  assign load_ready = (cnt == 3'd0) || (cnt == 3'd1 && res.ready);

  // Hold up to four results of one item and hand them out in order
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= load_cnt;
      idx <= 2'd0;
    end else if (take) begin
      cnt <= cnt - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= load_items;
    end
  end

  assign res.valid     = (cnt != 3'd0);
  assign res.action    = items[idx].action;
  assign res.spi_byte  = items[idx].spi_byte;
  assign res.host_byte = items[idx].host_byte;
  assign res.device_id = items[idx].device_id;
  assign res.last      = items[idx].last;

endmodule

// ===== hdl/snfs_checker.sv =====
module snfs_checker
  import snfs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_action,
  input logic [15:0] res_device_id
);

  // a stalled result holds its place
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // queue is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result shown after reset");

  // no new input while a result is stuck
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !cmd_ready)
    else $error("input taken while output stalled");

  // id only travels with done
  a_id_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_action != ACT_DONE |-> res_device_id == 16'h0000)
    else $error("device id outside done");

  // actions stay in range
  a_action: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_action <= ACT_DONE)
    else $error("bad action code");

endmodule

bind spi_nor_flash_sequencer_unit snfs_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_action    (res.action),
  .res_device_id (res.device_id)
);

// ===== test/snfs_tb_if.sv =====
`timescale 1ns / 1ps

// Bundles the testbench needs are the block's own interfaces; this file only
// collects the shared item type used by the stimulus tasks.
package snfs_tb_pkg;
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } flash_item_t;
endpackage

// ===== test/spi_nor_flash_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module spi_nor_flash_sequencer_unit_tb;
  import snfs_pkg::*;
  import snfs_tb_pkg::*;

  typedef enum int {
    S_IDLE, S_RD_HDR, S_RD_DATA, S_ID_HDR, S_ID_HI, S_ID_LO,
    S_W_RD_HDR, S_W_RD_DATA, S_ER_WE, S_E1_CMD, S_E1_STAT, S_ER_HDR,
    S_E2_CMD, S_E2_STAT, S_MERGE, S_PG_WE, S_PG_HDR, S_PG_DATA,
    S_PG_CMD, S_PG_STAT
  } seq_state_e;

  // Predicts the action stream and holds the actions not yet seen.
  class flash_action_scoreboard;
    res_t        pending[$];
    int          mismatches;
    int          checked;
    logic [7:0]  sector_copy[SECTOR_BYTES];
    seq_state_e  st;
    logic [23:0] cur_addr;
    logic [15:0] left;
    logic [11:0] sect_off;
    int          chunk;
    int          idx;
    logic [15:0] id_val;
    int          hdr;
    res_t        burst[$];

    function void push_act(logic [2:0] a, logic [7:0] sb, logic [7:0] hb, logic [15:0] id);
      res_t r;
      r.action = a; r.spi_byte = sb; r.host_byte = hb; r.device_id = id; r.last = 1'b0;
      burst.push_back(r);
    endfunction

    function logic [7:0] addr_byte(logic [23:0] a, int pos);
      return 8'(a >> (8 * (3 - pos)));
    endfunction

    function void sector_read_start();
      hdr = 0;
      push_act(ACT_CSLOW, 0, 0, 0); push_act(ACT_XCHG, OPC_READ, 0, 0);
      st = S_W_RD_HDR;
    endfunction

    function void page_start();
      push_act(ACT_CSLOW, 0, 0, 0); push_act(ACT_XCHG, OPC_WREN, 0, 0);
      st = S_PG_WE;
    endfunction

    function void cs_cycle(logic [7:0] opc);
      push_act(ACT_CSHIGH, 0, 0, 0); push_act(ACT_CSLOW, 0, 0, 0);
      push_act(ACT_XCHG, opc, 0, 0);
    endfunction

    // Advance the model by one accepted item and queue what it produces.
    function void note_item(flash_item_t it);
      logic [23:0] a;
      int rem;
      burst.delete();
      if (st == S_IDLE) begin
        if (it.kind == KIND_CMD && it.op == CMD_READ) begin
          cur_addr = it.address; left = it.length; hdr = 0;
          push_act(ACT_CSLOW, 0, 0, 0); push_act(ACT_XCHG, OPC_READ, 0, 0);
          st = S_RD_HDR;
        end else if (it.kind == KIND_CMD && it.op == CMD_WRITE) begin
          cur_addr = {it.address[23:12], 12'h000};
          sect_off = it.address[11:0];
          rem = SECTOR_BYTES - sect_off;
          left = it.length;
          chunk = (it.length <= rem) ? it.length : rem;
          sector_read_start();
        end else if (it.kind == KIND_CMD && it.op == CMD_ID) begin
          hdr = 0; id_val = 0;
          push_act(ACT_CSLOW, 0, 0, 0); push_act(ACT_XCHG, OPC_ID, 0, 0);
          st = S_ID_HDR;
        end
      end else if (st == S_MERGE) begin
        if (it.kind == KIND_HOST) begin
          sector_copy[(sect_off + idx) % SECTOR_BYTES] = it.data_byte;
          idx++;
          if (idx < chunk) push_act(ACT_REQ, 0, 0, 0);
          else begin
            idx = 0; page_start();
          end
        end
      end else if (it.kind == KIND_SPI) begin
        case (st)
          S_RD_HDR: begin
            hdr++;
            if (hdr < 4) push_act(ACT_XCHG, addr_byte(cur_addr, hdr), 0, 0);
            else if (left > 0) begin
              push_act(ACT_XCHG, DUMMY, 0, 0); st = S_RD_DATA;
            end else begin
              push_act(ACT_CSHIGH, 0, 0, 0); push_act(ACT_DONE, 0, 0, 0); st = S_IDLE;
            end
          end
          S_RD_DATA: begin
            push_act(ACT_HOST, 0, it.data_byte, 0);
            if (left > 0) left--;
            if (left > 0) push_act(ACT_XCHG, DUMMY, 0, 0);
            else begin
              push_act(ACT_CSHIGH, 0, 0, 0); push_act(ACT_DONE, 0, 0, 0); st = S_IDLE;
            end
          end
          S_ID_HDR: begin
            hdr++;
            if (hdr < 4) push_act(ACT_XCHG, 8'h00, 0, 0);
            else begin
              push_act(ACT_XCHG, DUMMY, 0, 0); st = S_ID_HI;
            end
          end
          S_ID_HI: begin
            id_val = {it.data_byte, 8'h00};
            push_act(ACT_XCHG, DUMMY, 0, 0); st = S_ID_LO;
          end
          S_ID_LO: begin
            id_val[7:0] = it.data_byte;
            push_act(ACT_CSHIGH, 0, 0, 0); push_act(ACT_DONE, 0, 0, id_val);
            st = S_IDLE;
          end
          S_W_RD_HDR: begin
            hdr++;
            if (hdr < 4) push_act(ACT_XCHG, addr_byte(cur_addr, hdr), 0, 0);
            else begin
              idx = 0; push_act(ACT_XCHG, DUMMY, 0, 0); st = S_W_RD_DATA;
            end
          end
          S_W_RD_DATA: begin
            sector_copy[idx % SECTOR_BYTES] = it.data_byte;
            idx++;
            if (idx < SECTOR_BYTES) push_act(ACT_XCHG, DUMMY, 0, 0);
            else begin
              cs_cycle(OPC_WREN); st = S_ER_WE;
            end
          end
          S_ER_WE: begin
            cs_cycle(OPC_RDSR); st = S_E1_CMD;
          end
          S_E1_CMD: begin push_act(ACT_XCHG, DUMMY, 0, 0); st = S_E1_STAT; end
          S_E2_CMD: begin push_act(ACT_XCHG, DUMMY, 0, 0); st = S_E2_STAT; end
          S_PG_CMD: begin push_act(ACT_XCHG, DUMMY, 0, 0); st = S_PG_STAT; end
          S_E1_STAT, S_E2_STAT, S_PG_STAT: begin
            push_act(ACT_CSHIGH, 0, 0, 0);
            if (it.data_byte[0]) begin
              // flash still busy: poll again
              push_act(ACT_CSLOW, 0, 0, 0); push_act(ACT_XCHG, OPC_RDSR, 0, 0);
              st = seq_state_e'(int'(st) - 1);
            end else if (st == S_E1_STAT) begin
              hdr = 0;
              push_act(ACT_CSLOW, 0, 0, 0); push_act(ACT_XCHG, OPC_ERASE, 0, 0);
              st = S_ER_HDR;
            end else if (st == S_E2_STAT) begin
              idx = 0;
              if (chunk > 0) begin
                push_act(ACT_REQ, 0, 0, 0); st = S_MERGE;
              end else page_start();
            end else if (idx < SECTOR_BYTES) page_start();
            else if (left <= chunk) begin
              push_act(ACT_DONE, 0, 0, 0); st = S_IDLE;
            end else begin
              // move on to the next sector
              left = 16'(left - chunk);
              cur_addr = cur_addr + 24'(SECTOR_BYTES);
              sect_off = 0;
              chunk = (left > SECTOR_BYTES) ? SECTOR_BYTES : left;
              sector_read_start();
            end
          end
          S_ER_HDR: begin
            hdr++;
            if (hdr < 4) push_act(ACT_XCHG, addr_byte(cur_addr, hdr), 0, 0);
            else begin
              cs_cycle(OPC_RDSR); st = S_E2_CMD;
            end
          end
          S_PG_WE: begin
            hdr = 0; cs_cycle(OPC_PROG); st = S_PG_HDR;
          end
          S_PG_HDR: begin
            hdr++;
            if (hdr < 4) push_act(ACT_XCHG, addr_byte(24'(cur_addr + idx), hdr), 0, 0);
            else begin
              push_act(ACT_XCHG, sector_copy[idx % SECTOR_BYTES], 0, 0); st = S_PG_DATA;
            end
          end
          S_PG_DATA: begin
            idx++;
            a = 24'(cur_addr + idx);
            if (idx < SECTOR_BYTES && a[7:0] != 0)
              push_act(ACT_XCHG, sector_copy[idx % SECTOR_BYTES], 0, 0);
            else begin
              cs_cycle(OPC_RDSR); st = S_PG_CMD;
            end
          end
          default: st = S_IDLE;
        endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: expected act=%0d spi=%h host=%h id=%h last=%b, got act=%0d spi=%h host=%h id=%h last=%b",
                   checked, want.action, want.spi_byte, want.host_byte, want.device_id,
                   want.last, got.action, got.spi_byte, got.host_byte, got.device_id,
                   got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  snfs_cmd_if cmd ();
  snfs_res_if res ();

  spi_nor_flash_sequencer_unit dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  flash_action_scoreboard board = new();
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  busy_polls  = 0;
  int  writes_done = 0;
  bit  hold_off    = 1'b0;
  int  burst_left  = 0;

  // Receiver: own stall pattern, plus a long hold-off when requested.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) res.ready <= 1'b0;
      else if (cycle_count % 64 < 20) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check results at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && res.valid && res.ready)
      board.check_result({res.action, res.spi_byte, res.host_byte, res.device_id, res.last});
    if (cycle_count > 3000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item; gaps between bursts of random length.
  task automatic send_item(flash_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    cmd.valid <= 1'b1;
    {cmd.kind, cmd.op, cmd.address, cmd.length, cmd.data_byte} <= it;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    board.note_item(it);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [1:0] op, logic [23:0] addr, logic [15:0] len);
    send_item({KIND_CMD, op, addr, len, 8'h00});
  endtask

  task automatic send_spi(logic [7:0] b);
    send_item({KIND_SPI, 2'($urandom), 24'($urandom), 16'($urandom), b});
  endtask

  task automatic send_host(logic [7:0] b);
    send_item({KIND_HOST, 2'($urandom), 24'($urandom), 16'($urandom), b});
  endtask

  // Junk of a wrong kind (or op 3) that the block must ignore.
  task automatic send_noise();
    flash_item_t it;
    it = {2'($urandom), 2'($urandom), 24'($urandom), 16'($urandom), 8'($urandom)};
    if (board.st == S_IDLE && it.kind == KIND_CMD) it.op = 2'd3;
    else if (board.st == S_MERGE && it.kind == KIND_HOST) it.kind = KIND_SPI;
    else if (board.st != S_IDLE && board.st != S_MERGE && it.kind == KIND_SPI)
      it.kind = 2'd3;
    send_item(it);
  endtask

  // Answer the flash side until the sequencer goes idle.
  task automatic run_to_idle(int busy_pct, int noise_pct);
    while (board.st != S_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise();
      else if (board.st == S_MERGE) send_host(8'($urandom));
      else if (board.st inside {S_E1_STAT, S_E2_STAT, S_PG_STAT}) begin
        if ($urandom_range(0, 99) < busy_pct) begin
          busy_polls++; send_spi(8'($urandom) | 8'h01);
        end else send_spi(8'($urandom) & 8'hFE);
      end else send_spi(8'($urandom));
    end
  endtask

  initial begin
    int r;
    cmd.valid = 1'b0;
    cmd.kind = '0; cmd.op = '0; cmd.address = '0; cmd.length = '0; cmd.data_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reads at the extremes, id read, noise while idle.
    send_noise();
    send_cmd(CMD_READ, 24'h000000, 16'd0); run_to_idle(0, 0);
    send_cmd(CMD_READ, 24'hFFFFFF, 16'd3);
    send_spi(8'h00); send_spi(8'hFF); send_spi(8'hA5); send_spi(8'h5A);
    send_spi(8'hFF); send_spi(8'h00); send_spi(8'h81); run_to_idle(0, 0);
    send_cmd(CMD_ID, 24'h123456, 16'hFFFF);
    send_spi(8'hEF); send_noise(); send_spi(8'h00); send_spi(8'h00); send_spi(8'h00);
    send_spi(8'hEF); send_spi(8'h14);
    // Zero-length write at the top sector, with busy polls.
    send_cmd(CMD_WRITE, 24'hFFFFFF, 16'd0); run_to_idle(30, 0);
    writes_done++;

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        send_cmd(CMD_READ, 24'($urandom), 16'd200); run_to_idle(0, 0);
      end
    join

    // Random: mostly reads and id reads, a few writes, one of them spanning sectors.
    while (items_sent < 480 || writes_done < 3) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_noise();
      else if (r < 55)
        send_cmd(CMD_READ, 24'($urandom),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) % 16'd600 : 16'($urandom_range(0, 8)));
      else if (r < 85) send_cmd(CMD_ID, 24'($urandom), 16'($urandom));
      else if (writes_done < 4) begin
        if (writes_done == 2)
          send_cmd(CMD_WRITE, {12'($urandom), 12'hFFE}, 16'($urandom_range(3, 6)));
        else
          send_cmd(CMD_WRITE, 24'($urandom), 16'($urandom_range(0, 40)));
        writes_done++;
      end
      run_to_idle(25, 5);
    end
    cmd.valid <= 1'b0;

    r = 0;
    while (board.pending.size() != 0 && r < 200000) begin
      @(posedge clk); r++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d results, %0d writes, %0d busy polls, long hold-off",
             items_sent, board.checked, writes_done, busy_polls);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("PASS");
    else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule
